// ----- rtl/fan_level_hysteresis_rpm_target_core_assert.svh -----
// assertion macros for the fan level hysteresis rpm target core
`ifndef FAN_LEVEL_HYSTERESIS_RPM_TARGET_CORE_ASSERT_SVH
`define FAN_LEVEL_HYSTERESIS_RPM_TARGET_CORE_ASSERT_SVH

// same-cycle implication
`define FLHR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define FLHR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/flhr_pkg.sv -----
// types, constants and fan curve tables for the fan level hysteresis core
package flhr_pkg;

   localparam int SENSORS    = 6;
   localparam int TABLE_ROWS = 6;
   localparam int MODES      = 2;
   localparam int FANS       = 2;
   localparam int SENSOR_W   = 3;
   localparam int ROW_W      = 3;

   typedef logic [7:0]          temp_type;
   typedef logic [11:0]         table_rpm_type;
   typedef logic [14:0]         rpm_type;
   typedef logic [1:0]          mode_type;
   typedef logic [SENSOR_W-1:0] sensor_id_type;
   typedef logic [ROW_W-1:0]    row_type;
   typedef logic [SENSORS-1:0]  sensor_mask_type;

   localparam mode_type THERMAL_MODE_UMA  = 2'd0;
   localparam mode_type THERMAL_MODE_GFX  = 2'd1;
   localparam mode_type THERMAL_MODE_NONE = 2'd2;

   localparam logic FAN_CPU = 1'b0;
   localparam logic FAN_SYS = 1'b1;

   localparam rpm_type RPM_PER_DEGREE = 15'd100;

   typedef struct packed {
      logic     req_type;
      temp_type ambient_temp;
      temp_type cpu_die_temp;
      temp_type cpu_board_temp;
      temp_type ssd_one_temp;
      temp_type ssd_two_temp;
      temp_type dram_temp;
      temp_type slot_temp;
   } req_payload_type;

   typedef struct packed {
      logic mode_sel;
      logic used;
   } lane_ctl_type;

   // [mode][fan]
   localparam sensor_mask_type FAN_SENSORS [MODES][FANS] = '{
      '{6'h03, 6'h1C},
      '{6'h03, 6'h34}
   };

   localparam temp_type START_TEMP [MODES][FANS] = '{
      '{8'd39, 8'd36},
      '{8'd40, 8'd39}
   };

   // [mode][sensor][row]
   localparam table_rpm_type CURVE_RPM [MODES][SENSORS][TABLE_ROWS] = '{
      '{
         '{12'd700, 12'd900, 12'd1100, 12'd1300, 12'd1700, 12'd2800},
         '{12'd700, 12'd900, 12'd1100, 12'd1300, 12'd1700, 12'd2800},
         '{12'd600, 12'd800, 12'd1000, 12'd1300, 12'd1700, 12'd2800},
         '{12'd600, 12'd800, 12'd1000, 12'd1300, 12'd1700, 12'd2800},
         '{12'd600, 12'd800, 12'd1000, 12'd1300, 12'd1700, 12'd2800},
         '{12'd0,   12'd0,   12'd0,    12'd0,    12'd0,    12'd0}
      },
      '{
         '{12'd800, 12'd900, 12'd1100, 12'd1300, 12'd1600, 12'd2800},
         '{12'd800, 12'd900, 12'd1100, 12'd1300, 12'd1600, 12'd2800},
         '{12'd500, 12'd600, 12'd900,  12'd1300, 12'd1600, 12'd2800},
         '{12'd0,   12'd0,   12'd0,    12'd0,    12'd0,    12'd0},
         '{12'd500, 12'd600, 12'd900,  12'd1300, 12'd1500, 12'd2800},
         '{12'd500, 12'd600, 12'd900,  12'd1300, 12'd1500, 12'd2800}
      }
   };

   localparam temp_type CURVE_RISE [MODES][SENSORS][TABLE_ROWS] = '{
      '{
         '{8'd60, 8'd70, 8'd78, 8'd89, 8'd96, 8'd96},
         '{8'd60, 8'd68, 8'd75, 8'd82, 8'd88, 8'd88},
         '{8'd53, 8'd54, 8'd55, 8'd58, 8'd62, 8'd62},
         '{8'd64, 8'd65, 8'd66, 8'd72, 8'd78, 8'd78},
         '{8'd55, 8'd60, 8'd65, 8'd69, 8'd72, 8'd72},
         '{8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0}
      },
      '{
         '{8'd60, 8'd70, 8'd78, 8'd89, 8'd96, 8'd96},
         '{8'd60, 8'd68, 8'd75, 8'd82, 8'd88, 8'd87},
         '{8'd60, 8'd62, 8'd65, 8'd67, 8'd71, 8'd66},
         '{8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0},
         '{8'd55, 8'd60, 8'd65, 8'd69, 8'd72, 8'd72},
         '{8'd54, 8'd57, 8'd60, 8'd64, 8'd71, 8'd71}
      }
   };

   localparam temp_type CURVE_FALL [MODES][SENSORS][TABLE_ROWS] = '{
      '{
         '{8'd39, 8'd57, 8'd67, 8'd75, 8'd85, 8'd95},
         '{8'd39, 8'd57, 8'd65, 8'd72, 8'd79, 8'd86},
         '{8'd36, 8'd51, 8'd52, 8'd53, 8'd56, 8'd60},
         '{8'd36, 8'd62, 8'd63, 8'd64, 8'd69, 8'd76},
         '{8'd36, 8'd53, 8'd58, 8'd63, 8'd67, 8'd70},
         '{8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0}
      },
      '{
         '{8'd40, 8'd57, 8'd67, 8'd75, 8'd87, 8'd95},
         '{8'd40, 8'd57, 8'd65, 8'd72, 8'd79, 8'd86},
         '{8'd39, 8'd52, 8'd56, 8'd59, 8'd61, 8'd64},
         '{8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0},
         '{8'd39, 8'd53, 8'd58, 8'd63, 8'd67, 8'd70},
         '{8'd39, 8'd50, 8'd54, 8'd58, 8'd62, 8'd69}
      }
   };

endpackage

// ----- rtl/flhr_if.sv -----
// request, response and control register channel interfaces
interface flhr_req_if;
   logic                     valid;
   logic                     ready;
   flhr_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface flhr_rsp_if;
   logic              valid;
   logic              ready;
   flhr_pkg::rpm_type speed_rpm;

   modport source (output valid, output speed_rpm, input ready);
   modport sink   (input valid, input speed_rpm, output ready);
endinterface

interface flhr_csr_if;
   logic               valid;
   logic               ready;
   flhr_pkg::mode_type thermal_mode;

   modport source (output valid, output thermal_mode, input ready);
   modport sink   (input valid, input thermal_mode, output ready);
endinterface

// ----- rtl/flhr_lane.sv -----
// per-sensor hysteresis level step and table rpm lookup
module flhr_lane #(
   parameter int NUM_LEVELS = 6,
   localparam int LEVEL_W   = $clog2(NUM_LEVELS)
) (
   input  flhr_pkg::lane_ctl_type  ctl,
   input  flhr_pkg::sensor_id_type sensor_id,
   input  flhr_pkg::temp_type      temp,
   input  logic [LEVEL_W-1:0]      level,
   output logic [LEVEL_W-1:0]      level_next,
   output flhr_pkg::table_rpm_type rpm
);
   import flhr_pkg::*;

   localparam logic [LEVEL_W-1:0] LEVEL_TOP = LEVEL_W'(NUM_LEVELS - 1);

   function automatic row_type row_of(input logic [LEVEL_W-1:0] lvl);
      row_type row;
      if (int'(lvl) >= TABLE_ROWS) begin
         row = ROW_W'(TABLE_ROWS - 1);
      end else begin
         row = ROW_W'(lvl);
      end
      return row;
   endfunction

   row_type            row_cur;
   logic               rise_hit;
   logic               fall_hit;
   logic [LEVEL_W-1:0] stepped;

   always_comb begin
      row_cur  = row_of(level);
      rise_hit = (level < LEVEL_TOP) &&
                 (temp >= CURVE_RISE[ctl.mode_sel][sensor_id][row_cur]);
      fall_hit = (level != '0) &&
                 (temp < CURVE_FALL[ctl.mode_sel][sensor_id][row_cur]);
      stepped  = level;
      if (rise_hit && !fall_hit) begin
         stepped = LEVEL_W'(level + LEVEL_W'(1));
      end else if (fall_hit && !rise_hit) begin
         stepped = LEVEL_W'(level - LEVEL_W'(1));
      end
      level_next = ctl.used ? stepped : level;
      rpm        = ctl.used ? CURVE_RPM[ctl.mode_sel][sensor_id][row_of(stepped)] : '0;
   end

endmodule

// ----- rtl/fan_level_hysteresis_rpm_target_core.sv -----
// top level: request register, level lanes, rpm max and response register
// accepted requests wait in the request register, results in the response register
// throughput: one request per cycle while responses are not stalled, set by the single
// compute stage between the request register and the response register
// reset: clears both stage valids, all sensor levels and thermal_mode to 0
module fan_level_hysteresis_rpm_target_core #(
   parameter int NUM_LEVELS = 6
) (
   input  logic       clock,
   input  logic       reset,
   flhr_req_if.sink   req_chan,
   flhr_rsp_if.source rsp_chan,
   flhr_csr_if.sink   csr_chan
);
   import flhr_pkg::*;

   `include "fan_level_hysteresis_rpm_target_core_assert.svh"

   localparam int LEVEL_W = $clog2(NUM_LEVELS);
   localparam logic [LEVEL_W-1:0] LEVEL_TOP = LEVEL_W'(NUM_LEVELS - 1);

   logic                              in_valid_ff, in_valid_in;
   req_payload_type                   in_data_ff, in_data_in;
   logic                              out_valid_ff, out_valid_in;
   rpm_type                           out_data_ff, out_data_in;
   mode_type                          mode_ff, mode_in;
   logic [SENSORS-1:0][LEVEL_W-1:0]   level_ff, level_in;

   logic                              advance;
   logic                              active;
   logic                              mode_sel;
   sensor_mask_type                   mask;
   temp_type                          start;
   temp_type                          temps [SENSORS];
   logic [SENSORS-1:0][LEVEL_W-1:0]   lane_level;
   table_rpm_type                     lane_rpm [SENSORS];
   table_rpm_type                     best;
   rpm_type                           addend;
   logic                              levels_ok;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.speed_rpm = out_data_ff;

   assign active   = (mode_ff == THERMAL_MODE_UMA) || (mode_ff == THERMAL_MODE_GFX);
   assign mode_sel = mode_ff[0];
   assign mask     = FAN_SENSORS[mode_sel][in_data_ff.req_type];
   assign start    = START_TEMP[mode_sel][in_data_ff.req_type];

   assign temps[0] = in_data_ff.cpu_die_temp;
   assign temps[1] = in_data_ff.cpu_board_temp;
   assign temps[2] = in_data_ff.ssd_one_temp;
   assign temps[3] = in_data_ff.ssd_two_temp;
   assign temps[4] = in_data_ff.dram_temp;
   assign temps[5] = in_data_ff.slot_temp;

   for (genvar i = 0; i < SENSORS; i++) begin : g_lane
      lane_ctl_type ctl;
      assign ctl.mode_sel = mode_sel;
      assign ctl.used     = mask[i];

      flhr_lane #(
         .NUM_LEVELS (NUM_LEVELS)
      ) u_lane (
         .ctl        (ctl),
         .sensor_id  (SENSOR_W'(i)),
         .temp       (temps[i]),
         .level      (level_ff[i]),
         .level_next (lane_level[i]),
         .rpm        (lane_rpm[i])
      );
   end

   always_comb begin
      best = '0;
      for (int i = 0; i < SENSORS; i++) begin
         if (lane_rpm[i] > best) begin
            best = lane_rpm[i];
         end
      end
      if (in_data_ff.ambient_temp >= start) begin
         addend = rpm_type'(in_data_ff.ambient_temp - start) * RPM_PER_DEGREE;
      end else begin
         addend = '0;
      end
   end

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      mode_in      = mode_ff;
      level_in     = level_ff;

      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
         in_data_in  = req_chan.payload;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = active ? rpm_type'(rpm_type'(best) + addend) : '0;
         if (active) begin
            level_in = lane_level;
         end
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      if (csr_chan.valid && csr_chan.ready) begin
         mode_in = csr_chan.thermal_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= THERMAL_MODE_UMA;
         level_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         mode_ff      <= mode_in;
         level_ff     <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   always_comb begin
      levels_ok = 1'b1;
      for (int i = 0; i < SENSORS; i++) begin
         if (level_ff[i] > LEVEL_TOP) begin
            levels_ok = 1'b0;
         end
      end
   end

   `FLHR_ASSERT_NOW(a_level_range, clock, reset, 1'b1, levels_ok)
   `FLHR_ASSERT_NEXT(a_levels_hold, clock, reset, !(advance && active), $stable(level_ff))
   `FLHR_ASSERT_NEXT(a_mode_none_zero, clock, reset, advance && !active, out_data_ff == '0)
   `FLHR_ASSERT_NOW(a_no_overwrite, clock, reset, req_chan.valid && req_chan.ready && in_valid_ff, advance)

endmodule

// ----- tb/sv/flhr_rpm_target_watch.sv -----
// watches the fan core channels, predicts each rpm target and compares responses
`timescale 1ns / 1ps
module flhr_rpm_target_watch #(
   parameter int NUM_LEVELS = 6
) (
   input  logic clock,
   input  logic reset,
   flhr_req_if  req_chan,
   flhr_rsp_if  rsp_chan,
   flhr_csr_if  csr_chan,
   output int   error_count,
   output int   rpm_pending,
   output int   rsp_seen
);
   import flhr_pkg::*;

   localparam int LEVEL_W = $clog2(NUM_LEVELS);

   logic [LEVEL_W-1:0] sensor_level [SENSORS];
   mode_type           cur_mode;
   rpm_type            rpm_due_q [$];

   task automatic report_mismatch(input string msg);
      if (error_count < 200) begin
         $display("%0t rpm target check: %s", $realtime, msg);
      end
      error_count++;
   endtask

   // steps the chosen fan's sensor levels, returns its speed; 0 outside uma and gfx
   function automatic rpm_type next_fan_speed(input req_payload_type r);
      temp_type        temps [SENSORS];
      sensor_mask_type used;
      logic            m;
      temp_type        start;
      int unsigned     lvl;
      int unsigned     nxt;
      int unsigned     row;
      int unsigned     best;
      int unsigned     total;
      if (cur_mode != THERMAL_MODE_UMA && cur_mode != THERMAL_MODE_GFX) begin
         return '0;
      end
      m     = (cur_mode == THERMAL_MODE_GFX);
      temps = '{r.cpu_die_temp, r.cpu_board_temp, r.ssd_one_temp,
                r.ssd_two_temp, r.dram_temp, r.slot_temp};
      used  = FAN_SENSORS[m][r.req_type];
      best  = 0;
      for (int s = 0; s < SENSORS; s++) begin
         if (used[s]) begin
            lvl = 32'(sensor_level[s]);
            row = (lvl < TABLE_ROWS) ? lvl : TABLE_ROWS - 1;
            nxt = lvl;
            if (lvl < NUM_LEVELS - 1 && temps[s] >= CURVE_RISE[m][s][row]) begin
               nxt++;
            end
            if (lvl > 0 && temps[s] < CURVE_FALL[m][s][row]) begin
               nxt--;
            end
            sensor_level[s] = nxt[LEVEL_W-1:0];
            row = (nxt < TABLE_ROWS) ? nxt : TABLE_ROWS - 1;
            if (32'(CURVE_RPM[m][s][row]) > best) begin
               best = 32'(CURVE_RPM[m][s][row]);
            end
         end
      end
      start = START_TEMP[m][r.req_type];
      total = best;
      if (r.ambient_temp >= start) begin
         total += 32'(r.ambient_temp - start) * 32'(RPM_PER_DEGREE);
      end
      return rpm_type'(total);
   endfunction

   always @(posedge clock) begin
      rpm_type want;
      if (reset) begin
         foreach (sensor_level[i]) begin
            sensor_level[i] = '0;
         end
         cur_mode = THERMAL_MODE_UMA;
         rpm_due_q.delete();
         error_count = 0;
         rsp_seen    = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_seen++;
            if (rpm_due_q.size() == 0) begin
               report_mismatch($sformatf("rpm %0d arrived with nothing outstanding",
                                         rsp_chan.speed_rpm));
            end else begin
               want = rpm_due_q.pop_front();
               if (rsp_chan.speed_rpm !== want) begin
                  report_mismatch($sformatf("fan speed got %0d want %0d",
                                            rsp_chan.speed_rpm, want));
               end
            end
         end
         if (csr_chan.valid && csr_chan.ready) begin
            cur_mode = csr_chan.thermal_mode;
         end
         if (req_chan.valid && req_chan.ready) begin
            rpm_due_q.push_back(next_fan_speed(req_chan.payload));
         end
      end
      rpm_pending <= rpm_due_q.size();
   end

endmodule

// ----- tb/sv/fan_level_hysteresis_rpm_target_core_test.sv -----
// stimulus and verdict for the fan level hysteresis rpm target core
`timescale 1ns / 1ps
module fan_level_hysteresis_rpm_target_core_test;
   import flhr_pkg::*;

   localparam int       QUIET_LIMIT        = 2000;
   localparam int       SEGMENTS           = 8;
   localparam int       SEGMENT_REQUESTS   = 191;
   localparam mode_type THERMAL_MODE_SPARE = 2'd3;
   localparam mode_type SEGMENT_MODE [SEGMENTS] = '{
      THERMAL_MODE_UMA, THERMAL_MODE_GFX, THERMAL_MODE_GFX, THERMAL_MODE_UMA,
      THERMAL_MODE_NONE, THERMAL_MODE_GFX, THERMAL_MODE_SPARE, THERMAL_MODE_UMA
   };
   localparam int unsigned IDLE_PCT  [4] = '{0, 57, 0, 38};
   localparam int unsigned STALL_PCT [4] = '{0, 0, 57, 38};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned idle_pct;
   int unsigned stall_pct;
   int          error_count;
   int          rpm_pending;
   int          rsp_seen;
   int          req_sent;
   int          quiet_cycles;
   temp_type    walk [7];

   flhr_req_if req_chan ();
   flhr_rsp_if rsp_chan ();
   flhr_csr_if csr_chan ();

   fan_level_hysteresis_rpm_target_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   flhr_rpm_target_watch u_watch (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_chan    (csr_chan),
      .error_count (error_count),
      .rpm_pending (rpm_pending),
      .rsp_seen    (rsp_seen)
   );

   always #4 clock = ~clock;

   function automatic req_payload_type make_req(
      input logic fan, input temp_type amb, input temp_type die, input temp_type board,
      input temp_type ssd_one, input temp_type ssd_two, input temp_type dram,
      input temp_type slot);
      req_payload_type p;
      p.req_type       = fan;
      p.ambient_temp   = amb;
      p.cpu_die_temp   = die;
      p.cpu_board_temp = board;
      p.ssd_one_temp   = ssd_one;
      p.ssd_two_temp   = ssd_two;
      p.dram_temp      = dram;
      p.slot_temp      = slot;
      return p;
   endfunction

   task automatic send_req(input req_payload_type p);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= p;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      req_sent++;
   endtask

   // hold off new requests until every outstanding rpm target is back
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (rpm_pending != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_mode(input mode_type m);
      csr_chan.valid        <= 1'b1;
      csr_chan.thermal_mode <= m;
      @(posedge clock);
      while (!csr_chan.ready) begin
         @(posedge clock);
      end
      csr_chan.valid <= 1'b0;
   endtask

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("fan_level_hysteresis_rpm_target_core_test: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int nxt;
      req_chan.valid        = 1'b0;
      req_chan.payload      = '0;
      csr_chan.valid        = 1'b0;
      csr_chan.thermal_mode = THERMAL_MODE_UMA;
      idle_pct              = 0;
      stall_pct             = 0;
      foreach (walk[k]) begin
         walk[k] = temp_type'($urandom_range(70, 30));
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // uma tables from reset: bottom level holds, climb to the top level and hold
      send_req(make_req(FAN_CPU, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      send_req(make_req(FAN_SYS, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
      for (int i = 0; i < 6; i++) begin
         send_req(make_req(FAN_CPU, i[0] ? 8'd39 : 8'd38, 8'd255, 8'd60,
                           8'd0, 8'd0, 8'd0, 8'd255));
      end
      for (int i = 0; i < 6; i++) begin
         send_req(make_req(FAN_SYS, i[0] ? 8'd36 : 8'd35, 8'd0, 8'd0,
                           8'd255, 8'd255, 8'd255, 8'd0));
      end
      // gfx tables keep the levels, then all readings cold so they fall
      drain();
      write_mode(THERMAL_MODE_GFX);
      for (int i = 0; i < 6; i++) begin
         send_req(make_req(i[0] ? FAN_SYS : FAN_CPU, i[1] ? 8'd255 : 8'd40,
                           8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      end
      drain();
      write_mode(THERMAL_MODE_NONE);
      send_req(make_req(FAN_CPU, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
      send_req(make_req(FAN_SYS, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
      drain();
      write_mode(THERMAL_MODE_SPARE);
      send_req(make_req(FAN_SYS, 8'd200, 8'd90, 8'd90, 8'd90, 8'd90, 8'd90, 8'd90));

      // drifting readings around the thresholds with occasional jumps
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain();
         write_mode(SEGMENT_MODE[seg]);
         idle_pct  = IDLE_PCT[seg / 2];
         stall_pct = STALL_PCT[seg / 2];
         for (int n = 0; n < SEGMENT_REQUESTS; n++) begin
            foreach (walk[k]) begin
               if ($urandom_range(99) < 8) begin
                  walk[k] = temp_type'($urandom_range(255));
               end else begin
                  nxt = int'(walk[k]) + int'($urandom_range(8)) - 4;
                  if (walk[k] > 100) nxt -= 3;
                  if (walk[k] < 25) nxt += 3;
                  walk[k] = temp_type'((nxt < 0) ? 0 : (nxt > 255) ? 255 : nxt);
               end
            end
            send_req(make_req(logic'($urandom_range(1)), walk[0], walk[1], walk[2],
                              walk[3], walk[4], walk[5], walk[6]));
            if ($urandom_range(99) == 0) begin
               drain();
            end
         end
      end

      drain();
      repeat (4) @(posedge clock);
      $display("run covered %0d requests and %0d rpm targets under four idle and stall mixes",
               req_sent, rsp_seen);
      $display("modes uma, gfx, none and the spare code ran with levels kept across changes");
      if (error_count == 0) begin
         $display("fan_level_hysteresis_rpm_target_core_test: clean");
      end else begin
         $display("fan_level_hysteresis_rpm_target_core_test: errors");
      end
      $finish;
   end

endmodule
